### src/fjq_pkg.sv
// ----------------------------------------------------------------------------
// fjq_pkg
// shared constants, codes, stream layout and control types of the
// four-class priority job queue
// ----------------------------------------------------------------------------
`default_nettype none

package fjq_pkg;

  // parameter defaults
  localparam int DEF_SIZE_LIMIT = 256;
  localparam int DEF_TAG_WIDTH  = 32;

  // configuration register
  localparam int             QSIZE_W     = 9;
  localparam logic [8:0]     QSIZE_RESET = 9'd256;

  // request kinds
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // classes
  localparam logic [1:0] CLS_LOW    = 2'd0;
  localparam logic [1:0] CLS_NORMAL = 2'd1;
  localparam logic [1:0] CLS_HIGH   = 2'd2;
  localparam logic [1:0] CLS_URGENT = 2'd3;
  localparam int         NUM_CLASSES = 4;

  // result status codes
  localparam logic [1:0] ST_ENQUEUED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_DEQUEUED = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // fixed field widths
  localparam int JOB_TAG_W = 32;
  localparam int TOTAL_W   = 9;
  localparam int COUNT_W   = 32;

  // stream layout
  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_TDATA_W = 112;

  localparam int OUT_TAG_LSB   = 0;
  localparam int OUT_PRIO_LSB  = 32;
  localparam int OUT_TOTAL_LSB = 34;
  localparam int OUT_SUB_LSB   = 43;
  localparam int OUT_DROP_LSB  = 75;
  localparam int OUT_PAD_LSB   = 107;

  // per-class fifo control
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fjq_fifo_ctl_t;

  // per-class fifo status
  typedef struct packed {
    logic full;
    logic empty;
  } fjq_fifo_sts_t;

  // storage depth of one class for a given maximum size
  function automatic int fjq_class_depth(input int max_size, input int cls);
    int depth;
    case (cls)
      2'd1:    depth = max_size >> 1;
      2'd2:    depth = max_size >> 2;
      default: depth = max_size >> 3;
    endcase
    return depth;
  endfunction

endpackage

`default_nettype wire

### src/fjq_class_fifo.sv
// ----------------------------------------------------------------------------
// fjq_class_fifo
// circular tag fifo of one priority class, wrapping at the configured
// capacity, with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fjq_class_fifo #(
  parameter int DEPTH     = 32,
  parameter int CAP_W     = 8,
  parameter int TAG_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire fjq_pkg::fjq_fifo_ctl_t ctl,
  input  wire logic [CAP_W-1:0]      cap,
  input  wire logic [TAG_WIDTH-1:0]  push_tag,
  output fjq_pkg::fjq_fifo_sts_t     sts,
  output logic [TAG_WIDTH-1:0]       rd_data
);
  import fjq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TAG_WIDTH-1:0] mem [DEPTH];
  logic [TAG_WIDTH-1:0] rd_data_r;
  logic [CAP_W-1:0]     head_inc, tail_inc;

  // status towards the request logic
  assign sts.full  = (CAP_W'(cnt_r) >= cap);
  assign sts.empty = (cnt_r == '0);
  assign rd_data   = rd_data_r;

  // pointer advance with wrap at capacity
  assign head_inc = CAP_W'(head_r) + CAP_W'(1);
  assign tail_inc = CAP_W'(tail_r) + CAP_W'(1);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      cnt_nxt  = '0;
    end else begin
      if (ctl.push) begin
        tail_nxt = (tail_inc >= cap) ? '0 : tail_inc[PTR_W-1:0];
        cnt_nxt  = cnt_r + CNT_W'(1);
      end
      if (ctl.pop) begin
        head_nxt = (head_inc >= cap) ? '0 : head_inc[PTR_W-1:0];
        cnt_nxt  = cnt_r - CNT_W'(1);
      end
    end
  end

  // pointer and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // tag storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= push_tag;
    end
    if (ctl.pop) begin
      rd_data_r <= mem[head_r];
    end
  end

endmodule

`default_nettype wire

### src/four_level_priority_job_queue_core.sv
// path: a request is accepted into an input register, and its result is then
//   taken into the result register, from which it is presented
// throughput: one request per cycle unless out_tready stalls the result;
//   the class pick is combinational, with one-write/one-read class tag memories
// reset: clears pointers, counts, totals and sets the queue size to 256;
//   the tag memories are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
// four_level_priority_job_queue_core
// strict-priority job queue with four class fifos, enqueue with drop on
// full class and dequeue of the oldest tag of the highest non-empty class
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_priority_job_queue_core #(
  parameter int SIZE_LIMIT = fjq_pkg::DEF_SIZE_LIMIT,
  parameter int TAG_WIDTH  = fjq_pkg::DEF_TAG_WIDTH
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // job_tag
  input  wire logic [fjq_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type, priority_req
  input  wire logic [fjq_pkg::IN_TUSER_W-1:0]    in_tuser,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // out_tag, out_priority, jobs_held, submitted_count, dropped_count, pad
  output logic [fjq_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // status
  output logic [fjq_pkg::OUT_TUSER_W-1:0]        out_tuser,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire logic [fjq_pkg::QSIZE_W-1:0]       cfg_wr_data
);
  import fjq_pkg::*;

  localparam int EFF_W = $clog2(SIZE_LIMIT + 1);
  localparam int CAP_W = $clog2((SIZE_LIMIT >> 1) + 1);
  localparam int CMP_W = (EFF_W > QSIZE_W) ? EFF_W : QSIZE_W;

  // input register
  logic                 in_valid_r;
  logic                 in_req_r;
  logic [1:0]           in_prio_r;
  logic [JOB_TAG_W-1:0] in_tag_r;

  // state and result registers
  logic [QSIZE_W-1:0]   qsize_r;
  logic [EFF_W-1:0]     total_r, total_nxt;
  logic [COUNT_W-1:0]   sub_r, sub_nxt;
  logic [COUNT_W-1:0]   drop_r, drop_nxt;
  logic                 out_valid_r;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [1:0]           out_prio_r, out_prio_nxt;

  logic                 advance, process;
  logic [CMP_W-1:0]     qsize_ext, eff_size;
  logic [CAP_W-1:0]     cap [NUM_CLASSES];
  fjq_fifo_ctl_t        ctl [NUM_CLASSES];
  fjq_fifo_sts_t        sts [NUM_CLASSES];
  logic [TAG_WIDTH-1:0] rd_data [NUM_CLASSES];
  logic [1:0]           pick;
  logic                 any_ready;
  logic                 push_any, pop_any, drop_any;
  logic [JOB_TAG_W-1:0] tag_shown;

  // pipeline handshake
  assign advance   = !out_valid_r || out_tready;
  assign process   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_req_r  <= in_tuser[0];
      in_prio_r <= in_tuser[2:1];
      in_tag_r  <= in_tdata;
    end
  end

  // effective size and per-class capacities
  assign qsize_ext = CMP_W'(qsize_r);
  assign eff_size  = (qsize_ext == '0 || qsize_ext > CMP_W'(SIZE_LIMIT))
                     ? CMP_W'(SIZE_LIMIT) : qsize_ext;

  assign cap[CLS_URGENT] = CAP_W'(eff_size >> 3);
  assign cap[CLS_HIGH]   = CAP_W'(eff_size >> 2);
  assign cap[CLS_NORMAL] = CAP_W'(eff_size >> 1);
  assign cap[CLS_LOW]    = CAP_W'(eff_size >> 3);

  // highest non-empty class
  always_comb begin
    pick      = CLS_LOW;
    any_ready = 1'b1;
    if (!sts[CLS_URGENT].empty) begin
      pick = CLS_URGENT;
    end else if (!sts[CLS_HIGH].empty) begin
      pick = CLS_HIGH;
    end else if (!sts[CLS_NORMAL].empty) begin
      pick = CLS_NORMAL;
    end else if (!sts[CLS_LOW].empty) begin
      pick = CLS_LOW;
    end else begin
      any_ready = 1'b0;
    end
  end

  // request decode
  always_comb begin
    push_any       = 1'b0;
    pop_any        = 1'b0;
    drop_any       = 1'b0;
    out_status_nxt = ST_EMPTY;
    out_prio_nxt   = CLS_LOW;
    if (in_req_r == REQ_ENQUEUE) begin
      if (sts[in_prio_r].full) begin
        drop_any       = process;
        out_status_nxt = ST_DROPPED;
      end else begin
        push_any       = process;
        out_status_nxt = ST_ENQUEUED;
      end
    end else if (any_ready) begin
      pop_any        = process;
      out_status_nxt = ST_DEQUEUED;
      out_prio_nxt   = pick;
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      ctl[c].clear = cfg_wr_en;
      ctl[c].push  = push_any && (in_prio_r == 2'(c));
      ctl[c].pop   = pop_any && (pick == 2'(c));
    end
  end

  // totals
  always_comb begin
    total_nxt = total_r;
    if (cfg_wr_en) begin
      total_nxt = '0;
    end else if (push_any) begin
      total_nxt = total_r + EFF_W'(1);
    end else if (pop_any) begin
      total_nxt = total_r - EFF_W'(1);
    end
    sub_nxt  = push_any ? sub_r + COUNT_W'(1) : sub_r;
    drop_nxt = drop_any ? drop_r + COUNT_W'(1) : drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r <= QSIZE_RESET;
      total_r <= '0;
      sub_r   <= '0;
      drop_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        qsize_r <= cfg_wr_data;
      end
      total_r <= total_nxt;
      sub_r   <= sub_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (process) begin
      out_status_r <= out_status_nxt;
      out_prio_r   <= out_prio_nxt;
    end
  end

  // class fifos
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_class
    fjq_class_fifo #(
      .DEPTH     (fjq_class_depth(SIZE_LIMIT, c)),
      .CAP_W     (CAP_W),
      .TAG_WIDTH (TAG_WIDTH)
    ) u_fifo (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl[c]),
      .cap      (cap[c]),
      .push_tag (TAG_WIDTH'(in_tag_r)),
      .sts      (sts[c]),
      .rd_data  (rd_data[c])
    );
  end

  // result channel
  assign tag_shown  = (out_status_r == ST_DEQUEUED) ? JOB_TAG_W'(rd_data[out_prio_r]) : '0;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {
    (OUT_TDATA_W - OUT_PAD_LSB)'(0),
    drop_r,
    sub_r,
    TOTAL_W'(total_r),
    out_prio_r,
    tag_shown
  };

endmodule

`default_nettype wire

### src/fjq_checker.sv
// ----------------------------------------------------------------------------
// fjq_checker
// port-level checks of the priority job queue, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module fjq_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [fjq_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [fjq_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import fjq_pkg::*;

  logic [1:0]         st;
  logic [TOTAL_W-1:0] total;

  assign st    = out_tuser;
  assign total = out_tdata[OUT_TOTAL_LSB +: TOTAL_W];

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // only a dequeue carries a tag and a class
  a_zero_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != ST_DEQUEUED |->
      out_tdata[OUT_TAG_LSB +: JOB_TAG_W] == '0 && out_tdata[OUT_PRIO_LSB +: 2] == '0)
    else $error("tag or class shown on a non-dequeue result");

  // an empty report means nothing is held
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_EMPTY |-> total == '0)
    else $error("empty reported with jobs queued");

  // a successful enqueue leaves at least one job held
  a_enq_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == ST_ENQUEUED |-> total != '0)
    else $error("enqueue reported with nothing queued");

endmodule

bind four_level_priority_job_queue_core fjq_checker u_fjq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
